/* rtl/bmpa_pkg.sv */
// Package for the bump arena allocator: field widths, fixed sizing constants,
// command and register codes, and the request and result word types.
// No dependencies.
package bmpa_pkg;

    localparam int SZ_W        = 21;
    localparam int ADDR_W      = 32;
    localparam int AL_W        = SZ_W + 1;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 104;

    localparam int SIZE_BITS = 20;
    localparam int ALIGNMENT = 16;

    localparam logic [SZ_W-1:0] CAP_RESET = SZ_W'(1048576);
    localparam logic [AL_W-1:0] SIZE_LIMIT =
        (SIZE_BITS >= AL_W) ? {AL_W{1'b1}} : (AL_W'(1) << SIZE_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_REALLOC = 2'd1,
        CMD_RESET   = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_BASE = 1'b0,
        CFG_CAPACITY    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              block_present;
        logic [ADDR_W-1:0] block_address;
        logic [SZ_W-1:0]   prior_size;
        logic [SZ_W-1:0]   request_size;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] result_address;
        logic              copy_needed;
        logic [SZ_W-1:0]   copy_length;
        logic [SZ_W-1:0]   used_bytes;
        logic [SZ_W-1:0]   available_bytes;
    } t_result;

endpackage

/* rtl/bmpa_align.sv */
// Two-stage round-up of a byte size to the next multiple of ALIGNMENT.
// The quotient comes from a reciprocal multiply, then is scaled back.
// Depends on bmpa_pkg.
module bmpa_align (
    input  logic                      i_clk,
    input  logic                      i_ld_q,
    input  logic                      i_ld_al,
    input  logic [bmpa_pkg::SZ_W-1:0] i_size,
    output logic [bmpa_pkg::AL_W-1:0] o_aligned
);
    import bmpa_pkg::*;

    localparam int LG    = $clog2(ALIGNMENT);
    localparam int SH    = AL_W + LG;
    localparam int MW    = AL_W + 2;
    localparam int PW    = AL_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(ALIGNMENT) - 64'd1) / 64'(ALIGNMENT));
    localparam logic [AL_W-1:0] ALIGN_V = AL_W'(ALIGNMENT);

    logic [AL_W-1:0] biased;
    logic [PW-1:0]   prod;
    logic [AL_W-1:0] n_q;
    logic [AL_W-1:0] r_q;
    logic [AL_W-1:0] n_al;
    logic [AL_W-1:0] r_al;

    always_comb begin
        biased = AL_W'(i_size) + AL_W'(ALIGNMENT - 1);
        prod   = PW'(biased) * PW'(RECIP);
        n_q    = AL_W'(prod >> SH);
        n_al   = r_q * ALIGN_V;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_q) begin
            r_q <= n_q;
        end
        if (i_ld_al) begin
            r_al <= n_al;
        end
    end

    assign o_aligned = r_al;

endmodule

/* rtl/bmpa_core.sv */
// Arena state and configuration registers, the per-command decision logic
// and the result register. Depends on bmpa_pkg.
module bmpa_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bmpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_ld,
    input  logic                            i_valid,
    input  bmpa_pkg::t_req                  i_req,
    input  logic [bmpa_pkg::AL_W-1:0]       i_al_old,
    input  logic [bmpa_pkg::AL_W-1:0]       i_al_req,
    output bmpa_pkg::t_result               o_res
);
    import bmpa_pkg::*;

    logic [ADDR_W-1:0] r_base;
    logic [SZ_W-1:0]   r_cap;
    logic [SZ_W-1:0]   r_used;
    logic [SZ_W-1:0]   n_used;
    t_result           r_res;
    t_result           n_res;

    logic [AL_W-1:0]   eff_cap;
    logic [AL_W:0]     alloc_end;
    logic              alloc_fit;
    logic [ADDR_W-1:0] alloc_addr;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W:0]   last_end;
    logic [ADDR_W:0]   move_end;
    logic              is_last;
    logic              move_fit;
    logic              req_zero;

    always_comb begin
        eff_cap    = ({1'b0, r_cap} < SIZE_LIMIT) ? {1'b0, r_cap} : SIZE_LIMIT;
        req_zero   = (i_req.request_size == '0);
        alloc_end  = (AL_W + 1)'(r_used) + (AL_W + 1)'(i_al_req);
        alloc_fit  = !req_zero && (alloc_end <= (AL_W + 1)'(eff_cap));
        alloc_addr = r_base + ADDR_W'(r_used);
        start      = i_req.block_address - r_base;
        last_end   = {1'b0, start} + (ADDR_W + 1)'(i_al_old);
        move_end   = {1'b0, start} + (ADDR_W + 1)'(i_al_req);
        is_last    = (last_end == (ADDR_W + 1)'(r_used));
        move_fit   = (move_end <= (ADDR_W + 1)'(eff_cap));

        n_used = r_used;
        n_res  = '0;
        unique case (i_req.command)
            CMD_ALLOC: begin
                if (alloc_fit) begin
                    n_res.ok             = 1'b1;
                    n_res.result_address = alloc_addr;
                    n_used               = SZ_W'(alloc_end);
                end
            end
            CMD_REALLOC: begin
                if (!i_req.block_present) begin
                    if (alloc_fit) begin
                        n_res.ok             = 1'b1;
                        n_res.result_address = alloc_addr;
                        n_used               = SZ_W'(alloc_end);
                    end
                end else if (!req_zero) begin
                    if (is_last) begin
                        if (move_fit) begin
                            n_res.ok             = 1'b1;
                            n_res.result_address = i_req.block_address;
                            n_used               = SZ_W'(move_end);
                        end
                    end else if (i_req.request_size <= i_req.prior_size) begin
                        n_res.ok             = 1'b1;
                        n_res.result_address = i_req.block_address;
                    end else if (alloc_fit) begin
                        n_res.ok             = 1'b1;
                        n_res.result_address = alloc_addr;
                        n_res.copy_needed    = 1'b1;
                        n_res.copy_length    = i_req.prior_size;
                        n_used               = SZ_W'(alloc_end);
                    end
                end
            end
            CMD_RESET: begin
                n_used   = '0;
                n_res.ok = 1'b1;
            end
            default: begin
            end
        endcase

        n_res.used_bytes      = n_used;
        n_res.available_bytes = (eff_cap > AL_W'(n_used)) ?
                                SZ_W'(eff_cap - AL_W'(n_used)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_cap  <= CAP_RESET;
            r_used <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_REGION_BASE: r_base <= ADDR_W'(i_cfg_wdata);
                    CFG_CAPACITY:    r_cap  <= SZ_W'(i_cfg_wdata);
                endcase
            end
            if (i_ld && i_valid) begin
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/bump_arena_allocator_unit.sv */
// Top level of the bump arena allocator: stream handshake, pipeline control,
// size rounding units and the arena core. Depends on bmpa_pkg, bmpa_align
// and bmpa_core.
//
//  channel  | direction | contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | one command word per transfer
//  m_axis   | out       | one result word per command, in command order
//  cfg      | in        | register writes, region_base (0) and capacity (1)
//
// Four register stages: input, rounding quotient, rounded sizes, result.
// One command is taken every cycle unless the output stalls. Only the final
// stage reads and updates the used offset. Reset empties the arena and the
// pipeline and restores the configuration defaults. A stalled output holds
// its word and backs up the pipeline; empty stages fill while the output
// waits.
module bump_arena_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // command, block_present, block_address, prior_size, request_size
    input  logic [bmpa_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // ok, result_address, copy_needed, copy_length, used_bytes,
    // available_bytes
    output logic [bmpa_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [bmpa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bmpa_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import bmpa_pkg::*;

    logic            r_v0;
    logic            r_v1;
    logic            r_v2;
    logic            r_v3;
    t_req            r_req0;
    t_req            r_req1;
    t_req            r_req2;
    t_req            in_req;
    logic            ld0;
    logic            ld1;
    logic            ld2;
    logic            ld3;
    logic [AL_W-1:0] al_old;
    logic [AL_W-1:0] al_req;
    t_result         res;

    always_comb begin
        in_req.command       = i_s_axis_tdata[1:0];
        in_req.block_present = i_s_axis_tdata[2];
        in_req.block_address = i_s_axis_tdata[34:3];
        in_req.prior_size    = i_s_axis_tdata[55:35];
        in_req.request_size  = i_s_axis_tdata[76:56];
    end

    assign ld3 = !r_v3 || i_m_axis_tready;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign ld0 = !r_v0 || ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0) begin
                r_v0 <= i_s_axis_tvalid;
            end
            if (ld1) begin
                r_v1 <= r_v0;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_req0 <= in_req;
        end
        if (ld1) begin
            r_req1 <= r_req0;
        end
        if (ld2) begin
            r_req2 <= r_req1;
        end
    end

    bmpa_align u_align_old (
        .i_clk     (i_clk),
        .i_ld_q    (ld1),
        .i_ld_al   (ld2),
        .i_size    (r_req0.prior_size),
        .o_aligned (al_old)
    );

    bmpa_align u_align_req (
        .i_clk     (i_clk),
        .i_ld_q    (ld1),
        .i_ld_al   (ld2),
        .i_size    (r_req0.request_size),
        .o_aligned (al_req)
    );

    bmpa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ld        (ld3),
        .i_valid     (r_v2),
        .i_req       (r_req2),
        .i_al_old    (al_old),
        .i_al_req    (al_req),
        .o_res       (res)
    );

    assign o_s_axis_tready = ld0;
    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {7'b0, res.available_bytes, res.used_bytes,
                              res.copy_length, res.copy_needed,
                              res.result_address, res.ok};

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_copy_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && res.copy_needed) |-> res.ok)
        else $error("copy request on a failed command");

    a_fail_is_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !res.ok) |->
            (res.result_address == '0 && res.copy_length == '0))
        else $error("failed command carries an address or copy length");

    a_avail_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((AL_W'(res.available_bytes) + AL_W'(res.used_bytes) <= SIZE_LIMIT) ||
             res.available_bytes == '0))
        else $error("used plus available exceeds the size limit");

endmodule
